### hdl/aabb_frustum_cull_top_assert.svh
// Assertion macros for the frustum culling block.
// AFC_ASSERT_IMP checks a same-cycle implication and AFC_ASSERT_NEXT checks a
// next-cycle implication. Both sample on the rising edge of clk and are
// disabled while rst_n is low.
`ifndef AABB_FRUSTUM_CULL_TOP_ASSERT_SVH
`define AABB_FRUSTUM_CULL_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define AFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum cull assertion failed");
`define AFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum cull assertion failed");
`else
`define AFC_ASSERT_IMP(label, ante, cons)
`define AFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/afc_pkg.sv
`timescale 1ns / 1ps

package afc_pkg;

    // Defaults for the top-level parameters.
    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_BITS_DEF  = 16;

    // Plane register packing: normal x, y, z (Q1.14) then offset (Q8.8).
    localparam int PLANE_BITS  = 64;
    localparam int NORMAL_BITS = 16;
    localparam int NORMAL_FRAC = 14;
    localparam int OFFSET_BITS = 16;

    // Width of the configuration register index; covers up to eight planes.
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [1:0] {
        REL_OUTSIDE   = 2'd0,
        REL_INTERSECT = 2'd1,
        REL_INSIDE    = 2'd2,
        REL_INVALID   = 2'd3
    } afc_relation_t;

    // Per-plane verdict handed from a plane lane to the result stage.
    typedef struct packed {
        logic near_pos;    // near corner lies strictly in front of the plane
        logic far_nonneg;  // far corner lies on or in front of the plane
    } afc_plane_flags_t;

endpackage

### hdl/afc_plane_lane.sv
`timescale 1ns / 1ps

// One plane of the test: picks the near and far corners, registers the six
// axis products and the offset, then sums and checks the signs.
module afc_plane_lane #(
    parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic [afc_pkg::PLANE_BITS-1:0]  plane,
    input  logic [2:0][COORD_BITS-1:0]      box_lo,
    input  logic [2:0][COORD_BITS-1:0]      box_hi,
    output afc_pkg::afc_plane_flags_t       flags
);
    import afc_pkg::*;

    localparam int PROD_W = NORMAL_BITS + COORD_BITS;
    localparam int OFS_W  = OFFSET_BITS + NORMAL_FRAC;
    localparam int ACC_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

    logic signed [NORMAL_BITS-1:0] normal     [3];
    logic signed [COORD_BITS-1:0]  near_coord [3];
    logic signed [COORD_BITS-1:0]  far_coord  [3];
    logic signed [PROD_W-1:0]      near_prod_next [3];
    logic signed [PROD_W-1:0]      far_prod_next  [3];
    logic signed [PROD_W-1:0]      near_prod_reg  [3];
    logic signed [PROD_W-1:0]      far_prod_reg   [3];
    logic signed [OFFSET_BITS-1:0] offset_reg;
    logic signed [ACC_W-1:0]       offset_term;
    logic signed [ACC_W-1:0]       near_sum;
    logic signed [ACC_W-1:0]       far_sum;

    // A positive normal component takes the box minimum for the near corner;
    // zero or negative takes the maximum.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            normal[a] = $signed(plane[a*NORMAL_BITS +: NORMAL_BITS]);
            if (normal[a] > 0)
            begin
                near_coord[a] = $signed(box_lo[a]);
                far_coord[a]  = $signed(box_hi[a]);
            end
            else
            begin
                near_coord[a] = $signed(box_hi[a]);
                far_coord[a]  = $signed(box_lo[a]);
            end
            near_prod_next[a] = normal[a] * near_coord[a];
            far_prod_next[a]  = normal[a] * far_coord[a];
        end
    end

    always_ff @(posedge clk)
    begin
        near_prod_reg <= near_prod_next;
        far_prod_reg  <= far_prod_next;
        offset_reg    <= $signed(plane[PLANE_BITS-1 -: OFFSET_BITS]);
    end

    // The offset is Q8.8 and the products Q.22, so it is scaled up by the
    // fraction width of the normal before it joins the sum.
    always_comb
    begin
        offset_term = ACC_W'(offset_reg) <<< NORMAL_FRAC;
        near_sum = ACC_W'(near_prod_reg[0]) + ACC_W'(near_prod_reg[1])
                 + ACC_W'(near_prod_reg[2]) + offset_term;
        far_sum  = ACC_W'(far_prod_reg[0]) + ACC_W'(far_prod_reg[1])
                 + ACC_W'(far_prod_reg[2]) + offset_term;
        flags.near_pos   = !near_sum[ACC_W-1] && (near_sum != '0);
        flags.far_nonneg = !far_sum[ACC_W-1];
    end

endmodule

### hdl/aabb_frustum_cull_top.sv
`timescale 1ns / 1ps

// Axis-aligned box versus frustum classifier. Pulse start with a box on the
// min and max ports; the block takes a new box on every cycle, so busy stays
// low and start may be held high for a continuous stream. After a box is taken,
// done is high for exactly one cycle with its relation
// (outside, intersect, inside, or invalid box); the three register stages are
// the input register, the product registers inside each plane lane, and the
// result register. Results come out in the order the boxes went in, and the
// receiver must take each one in the cycle it is shown, since there is no way
// to hold a result back. Planes are written through the cfg port, which is
// always ready; write them only while no box is in flight.
`include "aabb_frustum_cull_top_assert.svh"

module aabb_frustum_cull_top #(
    parameter int PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF,
    parameter int COORD_BITS  = afc_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       min_x,
    input  logic signed [COORD_BITS-1:0]       min_y,
    input  logic signed [COORD_BITS-1:0]       min_z,
    input  logic signed [COORD_BITS-1:0]       max_x,
    input  logic signed [COORD_BITS-1:0]       max_y,
    input  logic signed [COORD_BITS-1:0]       max_z,

    output logic                               done,
    output logic [1:0]                         relation,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [afc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [afc_pkg::PLANE_BITS-1:0]     cfg_data
);
    import afc_pkg::*;

    // Plane registers, each read only by its own lane.
    logic [PLANE_BITS-1:0] plane_reg [PLANE_COUNT];

    logic accept;
    logic box_invalid;
    logic box_empty;

    // Stage 1: the captured box and its validity checks.
    logic                        s1_valid_reg;
    logic                        s1_invalid_reg;
    logic                        s1_empty_reg;
    logic [2:0][COORD_BITS-1:0]  s1_lo_reg;
    logic [2:0][COORD_BITS-1:0]  s1_hi_reg;

    // Stage 2: the lanes hold their products; the box flags ride alongside.
    logic                        s2_valid_reg;
    logic                        s2_invalid_reg;
    logic                        s2_empty_reg;

    afc_plane_flags_t            lane_flags [PLANE_COUNT];
    logic                        any_near_pos;
    logic                        any_far_nonneg;

    // Result stage.
    logic                        done_reg;
    afc_relation_t               relation_reg;
    afc_relation_t               relation_next;

    // Every stage moves on each cycle, so the block never holds off a box.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Each plane register answers to its own index; an index past the last
    // plane matches none of them and the write is dropped.
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg[p] <= '0;
            end
            else if (cfg_valid && cfg_ready && (cfg_index == CFG_INDEX_BITS'(p)))
            begin
                plane_reg[p] <= cfg_data;
            end
        end

        afc_plane_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .clk    (clk),
            .plane  (plane_reg[p]),
            .box_lo (s1_lo_reg),
            .box_hi (s1_hi_reg),
            .flags  (lane_flags[p])
        );
    end

    // A box with its minimum above its maximum on any axis is invalid; one
    // whose corners coincide is empty. The invalid check wins over empty.
    assign box_invalid = (min_x > max_x) || (min_y > max_y) || (min_z > max_z);
    assign box_empty   = (min_x == max_x) && (min_y == max_y) && (min_z == max_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_invalid_reg <= box_invalid;
        s1_empty_reg   <= box_empty;
        s1_lo_reg      <= {min_z, min_y, min_x};
        s1_hi_reg      <= {max_z, max_y, max_x};
        s2_invalid_reg <= s1_invalid_reg;
        s2_empty_reg   <= s1_empty_reg;
        relation_reg   <= relation_next;
    end

    // Any plane that sees the near corner in front rejects the box outright.
    // Otherwise a plane that has the far corner on or in front means the box
    // straddles it, and the box is only inside when no plane is straddled.
    always_comb
    begin
        any_near_pos   = 1'b0;
        any_far_nonneg = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            any_near_pos   = any_near_pos   || lane_flags[p].near_pos;
            any_far_nonneg = any_far_nonneg || lane_flags[p].far_nonneg;
        end

        if (s2_invalid_reg)
        begin
            relation_next = REL_INVALID;
        end
        else if (s2_empty_reg || any_near_pos)
        begin
            relation_next = REL_OUTSIDE;
        end
        else if (any_far_nonneg)
        begin
            relation_next = REL_INTERSECT;
        end
        else
        begin
            relation_next = REL_INSIDE;
        end
    end

    assign done     = done_reg;
    assign relation = relation_reg;

    // Every taken box yields a done strobe once it has passed the pipeline.
    `AFC_ASSERT_IMP(a_latency, accept, ##3 done)
    // The invalid code appears exactly for boxes that failed the order check.
    `AFC_ASSERT_IMP(a_invalid_code, done, (relation == REL_INVALID) == $past(box_invalid, 3))
    // A valid empty box always comes out as outside.
    `AFC_ASSERT_IMP(a_empty_outside, done && $past(box_empty && !box_invalid, 3),
                    relation == REL_OUTSIDE)

endmodule

### bench/tb_aabb_frustum_cull_top.sv
`timescale 1ns / 1ps

// Testbench for the box versus frustum classifier.
//
// A single monitor process, clocked on the rising edge, does four things:
// it mirrors every accepted plane write into a local copy of the planes, it
// predicts the relation of every accepted box item from that copy, and it
// checks every result strobe against the oldest prediction still waiting,
// and it runs the watchdog. The stimulus side drives all inputs on the falling
// edge, so the monitor always sees settled values.
module tb_aabb_frustum_cull_top;
    import afc_pkg::*;

    localparam int PLANES        = PLANE_COUNT_DEF;
    localparam int CRD_BITS      = COORD_BITS_DEF;
    localparam int INDEX_SPAN    = 2 ** CFG_INDEX_BITS;
    // Input register, product registers and result register.
    localparam int LATENCY       = 3;
    localparam int RESET_CYCLES  = 9;
    // Far above the longest gap that pick_gap chooses, so this leaves a wide margin.
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 235;

    // Fixed point scales: Q1.14 for normals, Q8.8 for coordinates and offsets.
    localparam int ONE_Q14   = 16384;
    localparam int UNIT_Q8   = 256;
    localparam int COORD_MAX = 32767;
    localparam int COORD_MIN = -32768;

    typedef struct packed {
        logic [CRD_BITS-1:0] min_x;
        logic [CRD_BITS-1:0] min_y;
        logic [CRD_BITS-1:0] min_z;
        logic [CRD_BITS-1:0] max_x;
        logic [CRD_BITS-1:0] max_y;
        logic [CRD_BITS-1:0] max_z;
    } box_t;

    // Kinds of plane sets used by the random part.
    typedef enum int {
        PLANES_CUBE,
        PLANES_TILTED,
        PLANES_RAW,
        PLANES_EXTREME
    } plane_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      start = 1'b0;
    logic                      busy;
    logic [CRD_BITS-1:0]       min_x = '0;
    logic [CRD_BITS-1:0]       min_y = '0;
    logic [CRD_BITS-1:0]       min_z = '0;
    logic [CRD_BITS-1:0]       max_x = '0;
    logic [CRD_BITS-1:0]       max_y = '0;
    logic [CRD_BITS-1:0]       max_z = '0;
    logic                      done;
    logic [1:0]                relation;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [PLANE_BITS-1:0]     cfg_data = '0;

    // Local copy of the plane registers, as the block should hold them.
    logic [PLANE_BITS-1:0] plane_shadow [PLANES];
    // Relations predicted for boxes that have gone in but not come out yet.
    afc_relation_t         expected_relations [$];

    int fail_count   = 0;
    int stall_cycles = 0;
    // When set, the sender streams items back to back with no gaps.
    bit gapless      = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    aabb_frustum_cull_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .done      (done),
        .relation  (relation),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Classifies a box against the shadow planes with the p/n corner test.
    // All distances are kept exact in Q.22, so only their signs matter.
    function automatic afc_relation_t classify_box(box_t b);
        longint lo [3];
        longint hi [3];
        longint nrm;
        longint near_dist;
        longint far_dist;
        bit     flat;
        bit     crossed;
        lo[0] = $signed(b.min_x);
        lo[1] = $signed(b.min_y);
        lo[2] = $signed(b.min_z);
        hi[0] = $signed(b.max_x);
        hi[1] = $signed(b.max_y);
        hi[2] = $signed(b.max_z);
        flat = 1'b1;
        crossed = 1'b0;
        // A reversed axis is reported before the empty box check.
        for (int a = 0; a < 3; a++)
        begin
            if (lo[a] > hi[a])
                return REL_INVALID;
            if (lo[a] != hi[a])
                flat = 1'b0;
        end
        if (flat)
            return REL_OUTSIDE;
        for (int i = 0; i < PLANES; i++)
        begin
            near_dist = $signed(plane_shadow[i][63:48]);
            near_dist = near_dist * ONE_Q14;
            far_dist = near_dist;
            for (int a = 0; a < 3; a++)
            begin
                nrm = $signed(plane_shadow[i][16*a +: 16]);
                // A zero component takes the maximum for the near corner.
                if (nrm > 0)
                begin
                    near_dist += nrm * lo[a];
                    far_dist  += nrm * hi[a];
                end
                else
                begin
                    near_dist += nrm * hi[a];
                    far_dist  += nrm * lo[a];
                end
            end
            if (near_dist > 0)
                return REL_OUTSIDE;
            if (far_dist >= 0)
                crossed = 1'b1;
        end
        return crossed ? REL_INTERSECT : REL_INSIDE;
    endfunction

    function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.min_x = CRD_BITS'(x0);
        b.min_y = CRD_BITS'(y0);
        b.min_z = CRD_BITS'(z0);
        b.max_x = CRD_BITS'(x1);
        b.max_y = CRD_BITS'(y1);
        b.max_z = CRD_BITS'(z1);
        return b;
    endfunction

    function automatic logic [PLANE_BITS-1:0] pack_plane(int nx, int ny, int nz, int ofs);
        return {16'(ofs), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    function automatic int rand_coord();
        return int'($signed(16'($urandom)));
    endfunction

    function automatic int clip_coord(int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // Plane i of a set. In a cube set, planes pair up per axis with outward
    // normals of plus and minus one.
    function automatic logic [PLANE_BITS-1:0] make_plane(plane_set_t kind, int i);
        int f [4];
        for (int k = 0; k < 4; k++)
            f[k] = 0;
        case (kind)
            PLANES_CUBE:
            begin
                f[(i / 2) % 3] = (i % 2) ? -ONE_Q14 : ONE_Q14;
                f[3] = -int'($urandom_range(UNIT_Q8 / 2, 64 * UNIT_Q8));
            end
            PLANES_TILTED:
            begin
                for (int k = 0; k < 3; k++)
                    f[k] = int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14;
                f[3] = -int'($urandom_range(0, 48 * UNIT_Q8));
            end
            PLANES_RAW:
            begin
                for (int k = 0; k < 4; k++)
                    f[k] = rand_coord();
            end
            default:
            begin
                for (int k = 0; k < 4; k++)
                    case ($urandom_range(0, 3))
                        0: f[k] = COORD_MIN;
                        1: f[k] = COORD_MAX;
                        2: f[k] = 0;
                        default: f[k] = -1;
                    endcase
            end
        endcase
        return pack_plane(f[0], f[1], f[2], f[3]);
    endfunction

    // Most boxes are well formed with a random center and size at one of three
    // scales; the rest are full range, reversed on an axis, raw, empty or flat.
    function automatic box_t random_box();
        int lo [3];
        int hi [3];
        int kind;
        int span;
        int pick;
        int center;
        int half;
        int axis;
        int tmp;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        span = (pick < 55) ? 8 * UNIT_Q8 : (pick < 88) ? 32 * UNIT_Q8 : COORD_MAX;
        for (int a = 0; a < 3; a++)
        begin
            center = int'($urandom_range(0, 2 * span)) - span;
            half = $urandom_range(0, span / 2);
            lo[a] = clip_coord(center - half);
            hi[a] = clip_coord(center + half);
        end
        axis = $urandom_range(0, 2);
        if (kind < 12)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = rand_coord();
                hi[a] = rand_coord();
                if (lo[a] > hi[a])
                begin
                    tmp = lo[a];
                    lo[a] = hi[a];
                    hi[a] = tmp;
                end
            end
        end
        else if (kind < 20)
        begin
            if (hi[axis] == COORD_MAX)
            begin
                lo[axis] = COORD_MAX;
                hi[axis] = COORD_MAX - 1;
            end
            else
                lo[axis] = hi[axis] + 1;
        end
        else if (kind < 24)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = rand_coord();
                hi[a] = rand_coord();
            end
        end
        else if (kind < 29)
        begin
            for (int a = 0; a < 3; a++)
                hi[a] = lo[a];
        end
        else if (kind < 34)
            hi[axis] = lo[axis];
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (gapless)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one box item and returns at the edge where it is taken. Start
    // stays high into the next call when no gap follows, which keeps the
    // block streaming one item per cycle.
    task automatic send_box(input box_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        {min_x, min_y, min_z, max_x, max_y, max_z} <= b;
        do @(posedge clk); while (busy);
    endtask

    // Stops the sender and waits until every predicted relation has come out,
    // then lets the pipeline run empty for its full depth.
    task automatic wait_until_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_relations.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_plane(input int index, input logic [PLANE_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_BITS'(index);
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Loads a whole plane set while the block is idle. Half the time a write
    // to an index past the last plane goes along with it; the block must
    // drop that write.
    task automatic program_planes(input plane_set_t kind);
        wait_until_idle();
        for (int i = 0; i < PLANES; i++)
            write_plane(i, make_plane(kind, i));
        if ($urandom_range(0, 1))
            write_plane($urandom_range(PLANES, INDEX_SPAN - 1), {$urandom, $urandom});
    endtask

    // After reset every plane is zero, so every distance is zero: valid boxes
    // with volume or area cross, empty boxes are outside, reversed ones are
    // invalid even when the other axes are flat.
    task automatic test_reset_planes();
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(1, 5, 5, 0, 5, 5));
        send_box(make_box(0, COORD_MAX, 0, 0, COORD_MIN, 0));
        send_box(make_box(-3, -3, COORD_MAX, 3, 3, COORD_MIN));
        send_box(make_box(7, COORD_MIN, 7, 7, COORD_MAX, 7));
    endtask

    // An axis aligned cube of half size ten units. Each plane has two zero
    // normal components. Boxes touching a face land exactly on a zero
    // distance. The spare indices get all ones and must change nothing.
    task automatic test_axis_cube();
        wait_until_idle();
        for (int i = 0; i < PLANES; i++)
            write_plane(i, pack_plane((i / 2 == 0) ? ((i % 2) ? -ONE_Q14 : ONE_Q14) : 0,
                                      (i / 2 == 1) ? ((i % 2) ? -ONE_Q14 : ONE_Q14) : 0,
                                      (i / 2 == 2) ? ((i % 2) ? -ONE_Q14 : ONE_Q14) : 0,
                                      -10 * UNIT_Q8));
        for (int i = PLANES; i < INDEX_SPAN; i++)
            write_plane(i, '1);
        send_box(make_box(-UNIT_Q8, -UNIT_Q8, -UNIT_Q8, UNIT_Q8, UNIT_Q8, UNIT_Q8));
        send_box(make_box(11 * UNIT_Q8, 0, 0, 12 * UNIT_Q8, 1, 1));
        send_box(make_box(5 * UNIT_Q8, 0, 0, 15 * UNIT_Q8, 1, 1));
        send_box(make_box(10 * UNIT_Q8, 0, 0, 12 * UNIT_Q8, 1, 1));
        send_box(make_box(-10 * UNIT_Q8, -10 * UNIT_Q8, -10 * UNIT_Q8,
                          10 * UNIT_Q8, 10 * UNIT_Q8, 10 * UNIT_Q8));
        send_box(make_box(-9 * UNIT_Q8, -9 * UNIT_Q8, -9 * UNIT_Q8,
                          9 * UNIT_Q8, 9 * UNIT_Q8, 9 * UNIT_Q8));
        send_box(make_box(0, 0, -20 * UNIT_Q8, 1, 1, -11 * UNIT_Q8));
    endtask

    // One plane with the most negative and most positive normal components,
    // a zero component and the most negative offset. The other planes sit
    // just behind every point, so only the first plane decides.
    task automatic test_extreme_planes();
        wait_until_idle();
        write_plane(0, pack_plane(COORD_MIN, COORD_MAX, 0, COORD_MIN));
        for (int i = 1; i < PLANES; i++)
            write_plane(i, pack_plane(0, 0, 0, -1));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(0, 0, 0, UNIT_Q8, UNIT_Q8, UNIT_Q8));
        send_box(make_box(COORD_MIN, COORD_MAX - 1, 0, COORD_MIN + 1, COORD_MAX, 0));
        send_box(make_box(COORD_MAX - 1, COORD_MIN, 5, COORD_MAX, COORD_MIN + 1, 9));
    endtask

    // Random boxes over several plane sets. Every third phase streams with no
    // gaps; halfway through each phase the sender drains the block once.
    task automatic test_random_boxes();
        plane_set_t kind;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: kind = PLANES_CUBE;
                1: kind = PLANES_TILTED;
                2: kind = PLANES_RAW;
                default: kind = PLANES_EXTREME;
            endcase
            program_planes(kind);
            gapless = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_until_idle();
                send_box(random_box());
            end
        end
        gapless = 1'b0;
    endtask

    // Monitor: mirrors plane writes, checks results, predicts new items, and
    // runs the watchdog over cycles in which no write, result or box moves.
    always @(posedge clk)
    begin
        bit            moved;
        afc_relation_t want;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < PLANES)
                    plane_shadow[cfg_index] = cfg_data;
                moved = 1'b1;
            end
            if (done)
            begin
                moved = 1'b1;
                if (expected_relations.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("relation %0d came out with no box pending", relation);
                end
                else
                begin
                    want = expected_relations.pop_front();
                    if (relation !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("relation mismatch: expected %s, got %0d",
                                     want.name(), relation);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_relations.push_back(
                    classify_box({min_x, min_y, min_z, max_x, max_y, max_z}));
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < PLANES; i++)
            plane_shadow[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_planes();
        test_axis_cube();
        test_extreme_planes();
        test_random_boxes();

        wait_until_idle();
        repeat (LATENCY + 2) @(negedge clk);
        fail_count += expected_relations.size();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
